// File: hw/rtl/iexu_pkg.sv
package iexu_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam logic [31:0] InsnBytes = 32'd4;

  typedef enum logic [4:0] {
    CMD_ADDI    = 5'd0,
    CMD_SLTI    = 5'd1,
    CMD_SLTIU   = 5'd2,
    CMD_XORI    = 5'd3,
    CMD_ORI     = 5'd4,
    CMD_ANDI    = 5'd5,
    CMD_LUI     = 5'd6,
    CMD_AUIPC   = 5'd7,
    CMD_JAL     = 5'd8,
    CMD_JALR    = 5'd9,
    CMD_BEQ     = 5'd10,
    CMD_BNE     = 5'd11,
    CMD_BLT     = 5'd12,
    CMD_BGE     = 5'd13,
    CMD_BLTU    = 5'd14,
    CMD_BGEU    = 5'd15,
    CMD_SLLI    = 5'd16,
    CMD_SRLI    = 5'd17,
    CMD_SRAI    = 5'd18,
    CMD_ADD     = 5'd19,
    CMD_SUB     = 5'd20,
    CMD_SLL     = 5'd21,
    CMD_SLT     = 5'd22,
    CMD_SLTU    = 5'd23,
    CMD_XOR     = 5'd24,
    CMD_SRL     = 5'd25,
    CMD_SRA     = 5'd26,
    CMD_OR      = 5'd27,
    CMD_AND     = 5'd28,
    CMD_PRELOAD = 5'd29,
    CMD_READ    = 5'd30
  } cmd_e;

  typedef enum logic [3:0] {
    ALU_NONE  = 4'd0,
    ALU_ADD   = 4'd1,
    ALU_SUB   = 4'd2,
    ALU_SLT   = 4'd3,
    ALU_SLTU  = 4'd4,
    ALU_XOR   = 4'd5,
    ALU_OR    = 4'd6,
    ALU_AND   = 4'd7,
    ALU_SLL   = 4'd8,
    ALU_SRL   = 4'd9,
    ALU_SRA   = 4'd10,
    ALU_LUI   = 4'd11,
    ALU_AUIPC = 4'd12,
    ALU_LINK  = 4'd13,
    ALU_PRE   = 4'd14,
    ALU_PASSA = 4'd15
  } alu_op_e;

  typedef enum logic [2:0] {
    BR_EQ  = 3'd0,
    BR_NE  = 3'd1,
    BR_LT  = 3'd2,
    BR_GE  = 3'd3,
    BR_LTU = 3'd4,
    BR_GEU = 3'd5
  } br_op_e;

  typedef struct packed {
    alu_op_e     alu_op;
    logic        use_imm;
    logic        writes;
    logic        is_jal;
    logic        is_jalr;
    logic        is_branch;
    br_op_e      br_op;
    logic [4:0]  dest;
    logic [4:0]  src1;
    logic [4:0]  src2;
    logic [31:0] imm;
    logic [31:0] pre;
    logic [31:0] pc;
  } uop_t;

endpackage

// File: hw/rtl/iexu_front.sv
module iexu_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [4:0]        command_i,
  input  logic [4:0]        dest_reg_i,
  input  logic [4:0]        src1_reg_i,
  input  logic [4:0]        src2_reg_i,
  input  logic [31:0]       immediate_i,
  input  logic [31:0]       preload_value_i,
  input  logic [31:0]       current_address_i,
  output logic              push_o,
  output iexu_pkg::uop_t    uop_o,
  input  logic              q_ready_i
);
  import iexu_pkg::*;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i & q_ready_i;

  always_comb begin
    uop_o           = '0;
    uop_o.alu_op    = ALU_NONE;
    uop_o.br_op     = BR_EQ;
    uop_o.writes    = 1'b1;
    uop_o.dest      = dest_reg_i;
    uop_o.src1      = src1_reg_i;
    uop_o.src2      = src2_reg_i;
    uop_o.imm       = immediate_i;
    uop_o.pre       = preload_value_i;
    uop_o.pc        = current_address_i;
    case (cmd_e'(command_i))
      CMD_ADDI: begin
        uop_o.alu_op = ALU_ADD; uop_o.use_imm = 1'b1;
      end
      CMD_SLTI: begin
        uop_o.alu_op = ALU_SLT; uop_o.use_imm = 1'b1;
      end
      CMD_SLTIU: begin
        uop_o.alu_op = ALU_SLTU; uop_o.use_imm = 1'b1;
      end
      CMD_XORI: begin
        uop_o.alu_op = ALU_XOR; uop_o.use_imm = 1'b1;
      end
      CMD_ORI: begin
        uop_o.alu_op = ALU_OR; uop_o.use_imm = 1'b1;
      end
      CMD_ANDI: begin
        uop_o.alu_op = ALU_AND; uop_o.use_imm = 1'b1;
      end
      CMD_LUI:   uop_o.alu_op = ALU_LUI;
      CMD_AUIPC: uop_o.alu_op = ALU_AUIPC;
      CMD_JAL: begin
        uop_o.alu_op = ALU_LINK; uop_o.is_jal = 1'b1;
      end
      CMD_JALR: begin
        uop_o.alu_op = ALU_LINK; uop_o.is_jalr = 1'b1;
      end
      CMD_BEQ: begin
        uop_o.writes = 1'b0; uop_o.is_branch = 1'b1; uop_o.br_op = BR_EQ;
      end
      CMD_BNE: begin
        uop_o.writes = 1'b0; uop_o.is_branch = 1'b1; uop_o.br_op = BR_NE;
      end
      CMD_BLT: begin
        uop_o.writes = 1'b0; uop_o.is_branch = 1'b1; uop_o.br_op = BR_LT;
      end
      CMD_BGE: begin
        uop_o.writes = 1'b0; uop_o.is_branch = 1'b1; uop_o.br_op = BR_GE;
      end
      CMD_BLTU: begin
        uop_o.writes = 1'b0; uop_o.is_branch = 1'b1; uop_o.br_op = BR_LTU;
      end
      CMD_BGEU: begin
        uop_o.writes = 1'b0; uop_o.is_branch = 1'b1; uop_o.br_op = BR_GEU;
      end
      CMD_SLLI: begin
        uop_o.alu_op = ALU_SLL; uop_o.use_imm = 1'b1;
      end
      CMD_SRLI: begin
        uop_o.alu_op = ALU_SRL; uop_o.use_imm = 1'b1;
      end
      CMD_SRAI: begin
        uop_o.alu_op = ALU_SRA; uop_o.use_imm = 1'b1;
      end
      CMD_ADD:     uop_o.alu_op = ALU_ADD;
      CMD_SUB:     uop_o.alu_op = ALU_SUB;
      CMD_SLL:     uop_o.alu_op = ALU_SLL;
      CMD_SLT:     uop_o.alu_op = ALU_SLT;
      CMD_SLTU:    uop_o.alu_op = ALU_SLTU;
      CMD_XOR:     uop_o.alu_op = ALU_XOR;
      CMD_SRL:     uop_o.alu_op = ALU_SRL;
      CMD_SRA:     uop_o.alu_op = ALU_SRA;
      CMD_OR:      uop_o.alu_op = ALU_OR;
      CMD_AND:     uop_o.alu_op = ALU_AND;
      CMD_PRELOAD: uop_o.alu_op = ALU_PRE;
      CMD_READ: begin
        uop_o.alu_op = ALU_PASSA; uop_o.writes = 1'b0;
      end
      default: begin
        uop_o.alu_op = ALU_NONE; uop_o.writes = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/iexu_queue.sv
module iexu_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  iexu_pkg::uop_t push_uop_i,
  output logic           ready_o,
  output logic           valid_o,
  output iexu_pkg::uop_t head_o,
  input  logic           pop_i
);
  import iexu_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] Full = CntW'(QueueDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  uop_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;

  assign ready_o = (count_q != Full);
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_uop_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != Full) || pop_i)
    else $error("Item pushed into a full queue.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("Item popped from an empty queue.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("Queue count exceeds its depth.");

endmodule

// File: hw/rtl/iexu_back.sv
module iexu_back #(
  parameter int unsigned REGISTER_COUNT = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  iexu_pkg::uop_t q_head_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [31:0]    result_value_o,
  output logic           wrote_register_o,
  output logic [31:0]    next_address_o,
  output logic           branch_taken_o
);
  import iexu_pkg::*;

  localparam int unsigned IdxW = $clog2(REGISTER_COUNT);
  localparam logic [5:0]  RegCnt = 6'(REGISTER_COUNT);

  logic [31:0]               mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] valid_q;

  uop_t        ex_q;
  logic        ex_v_q;
  logic [31:0] rd1_q, rd2_q;
  logic        rv1_q, rv2_q;
  logic        byp_en_q;
  logic [4:0]  byp_addr_q;
  logic [31:0] byp_data_q;

  logic        out_v_q;
  logic [31:0] out_val_q, out_next_q;
  logic        out_wrote_q, out_taken_q;

  logic            ex_adv, load, wr_en;
  logic [IdxW-1:0] wr_idx, rs1_idx, rs2_idx;
  logic            rs1_ok, rs2_ok;
  logic [31:0]     a, b, opb, val, next, link, target;
  logic [4:0]      sh;
  logic            cond, taken;

  assign ex_adv  = ex_v_q & (~out_v_q | out_ready_i);
  assign load    = q_valid_i & (~ex_v_q | ex_adv);
  assign q_pop_o = load;

  assign rs1_idx = q_head_i.src1[IdxW-1:0];
  assign rs2_idx = q_head_i.src2[IdxW-1:0];
  assign rs1_ok  = (q_head_i.src1 != '0) && ({1'b0, q_head_i.src1} < RegCnt);
  assign rs2_ok  = (q_head_i.src2 != '0) && ({1'b0, q_head_i.src2} < RegCnt);

  always_comb begin
    if (byp_en_q && byp_addr_q == ex_q.src1) begin
      a = byp_data_q;
    end else begin
      a = rv1_q ? rd1_q : '0;
    end
    if (byp_en_q && byp_addr_q == ex_q.src2) begin
      b = byp_data_q;
    end else begin
      b = rv2_q ? rd2_q : '0;
    end
  end

  assign opb    = ex_q.use_imm ? ex_q.imm : b;
  assign sh     = opb[4:0];
  assign link   = ex_q.pc + InsnBytes;
  assign target = ex_q.pc + ex_q.imm;

  always_comb begin
    case (ex_q.alu_op)
      ALU_ADD:   val = a + opb;
      ALU_SUB:   val = a - b;
      ALU_SLT:   val = {31'd0, $signed(a) < $signed(opb)};
      ALU_SLTU:  val = {31'd0, a < opb};
      ALU_XOR:   val = a ^ opb;
      ALU_OR:    val = a | opb;
      ALU_AND:   val = a & opb;
      ALU_SLL:   val = a << sh;
      ALU_SRL:   val = a >> sh;
      ALU_SRA:   val = 32'($signed(a) >>> sh);
      ALU_LUI:   val = {ex_q.imm[19:0], 12'd0};
      ALU_AUIPC: val = ex_q.pc + {ex_q.imm[19:0], 12'd0};
      ALU_LINK:  val = link;
      ALU_PRE:   val = ex_q.pre;
      ALU_PASSA: val = a;
      default:   val = '0;
    endcase
  end

  always_comb begin
    case (ex_q.br_op)
      BR_EQ:   cond = (a == b);
      BR_NE:   cond = (a != b);
      BR_LT:   cond = $signed(a) < $signed(b);
      BR_GE:   cond = $signed(a) >= $signed(b);
      BR_LTU:  cond = a < b;
      BR_GEU:  cond = a >= b;
      default: cond = 1'b0;
    endcase
  end

  always_comb begin
    next  = link;
    taken = 1'b0;
    if (ex_q.is_jal) begin
      next  = target;
      taken = 1'b1;
    end else if (ex_q.is_jalr) begin
      next  = (a + ex_q.imm) & ~32'd1;
      taken = 1'b1;
    end else if (ex_q.is_branch && cond) begin
      next  = target;
      taken = 1'b1;
    end
  end

  assign wr_en  = ex_adv & ex_q.writes & (ex_q.dest != '0) & ({1'b0, ex_q.dest} < RegCnt);
  assign wr_idx = ex_q.dest[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= val;
    end
    if (load) begin
      rd1_q <= mem[rs1_idx];
      rd2_q <= mem[rs2_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      ex_v_q   <= 1'b0;
      byp_en_q <= 1'b0;
      rv1_q    <= 1'b0;
      rv2_q    <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (load) begin
        ex_v_q   <= 1'b1;
        rv1_q    <= rs1_ok & valid_q[rs1_idx];
        rv2_q    <= rs2_ok & valid_q[rs2_idx];
        byp_en_q <= wr_en;
      end else if (ex_adv) begin
        ex_v_q <= 1'b0;
      end
      if (ex_adv) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ex_q       <= q_head_i;
      byp_addr_q <= ex_q.dest;
      byp_data_q <= val;
    end
    if (ex_adv) begin
      out_val_q   <= val;
      out_wrote_q <= wr_en;
      out_next_q  <= next;
      out_taken_q <= taken;
    end
  end

  assign out_valid_o      = out_v_q;
  assign result_value_o   = out_val_q;
  assign wrote_register_o = out_wrote_q;
  assign next_address_o   = out_next_q;
  assign branch_taken_o   = out_taken_q;

  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ex_q.dest != '0)
    else $error("Register x0 was written.");

  a_write_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> valid_q[$past(wr_idx)])
    else $error("Written register is not marked valid.");

  a_ex_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_v_q && !ex_adv |=> ex_v_q && $stable(ex_q))
    else $error("Stalled item in the execute stage changed.");

  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_adv && !out_v_q |=> out_v_q)
    else $error("Finished item did not reach the output register.");

endmodule

// File: hw/rtl/integer_execute_unit_with_register_file.sv
// An accepted item passes through the queue, the execute stage register and the output register, in that order.
// Throughput: one item per cycle while out_ready_i does not hold the output,
// set by the single execute stage and the registered two-port register file
// read, with a one-entry bypass for the preceding write.
// Reset clears all control state and marks every register as zero through
// per-entry valid bits, so no clearing pass is needed.
module integer_execute_unit_with_register_file #(
  parameter int unsigned REGISTER_COUNT = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [4:0]         command_i,
  input  logic [4:0]         dest_reg_i,
  input  logic [4:0]         src1_reg_i,
  input  logic [4:0]         src2_reg_i,
  input  logic signed [31:0] immediate_i,
  input  logic [31:0]        preload_value_i,
  input  logic [31:0]        current_address_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        result_value_o,
  output logic               wrote_register_o,
  output logic [31:0]        next_address_o,
  output logic               branch_taken_o
);
  import iexu_pkg::*;

  logic push, q_ready, q_valid, q_pop;
  uop_t push_uop, head_uop;

  iexu_front u_front (
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .dest_reg_i        (dest_reg_i),
    .src1_reg_i        (src1_reg_i),
    .src2_reg_i        (src2_reg_i),
    .immediate_i       ($unsigned(immediate_i)),
    .preload_value_i   (preload_value_i),
    .current_address_i (current_address_i),
    .push_o            (push),
    .uop_o             (push_uop),
    .q_ready_i         (q_ready)
  );

  iexu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_uop_i (push_uop),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .head_o     (head_uop),
    .pop_i      (q_pop)
  );

  iexu_back #(
    .REGISTER_COUNT (REGISTER_COUNT)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_head_i         (head_uop),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_value_o   (result_value_o),
    .wrote_register_o (wrote_register_o),
    .next_address_o   (next_address_o),
    .branch_taken_o   (branch_taken_o)
  );

endmodule
